// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ===== design/kerl_pkg.sv =====
// ----------------------------------------------------------------------------
// kerl_pkg
// Shared types and constants of the keyed event rate limiter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kerl_pkg;

  localparam int SLOT_COUNT_DEF = 8;

  localparam int KEY_W      = 64;
  localparam int TIME_W     = 63;
  localparam int WIN_W      = 40;
  localparam int CNT_W      = 16;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 4;
  // 8-byte register spacing: register index sits above the byte offset
  localparam int CFG_IDX_LSB = 3;

  localparam logic REG_WINDOW_IDX = 1'b0;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 40'd7200000000;
  localparam logic [CNT_W-1:0] REPEAT_MAX   = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_READ,
    ST_COMMIT
  } kerl_state_e;

  typedef struct packed {
    logic capture;  // latch the incoming item
    logic match;    // register tag search result
    logic read;     // read stamp and count of the hit slot
    logic commit;   // update table, load result register
  } kerl_cmd_t;

  typedef struct packed {
    logic hit;
  } kerl_status_t;

endpackage

`default_nettype wire

// ===== design/kerl_ctrl.sv =====
// ----------------------------------------------------------------------------
// kerl_ctrl
// Sequencer for lookup, read and commit; owns the result handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kerl_ctrl
  import kerl_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  input  wire kerl_status_t status_i,
  output kerl_cmd_t         cmd_o
);

  kerl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_MATCH;
        end
      end
      ST_MATCH: begin
        cmd_o.match = 1'b1;
        state_d     = status_i.hit ? ST_READ : ST_COMMIT;
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_COMMIT;
      end
      ST_COMMIT: begin
        // wait until the result register is free or being drained
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== design/kerl_dp.sv =====
// ----------------------------------------------------------------------------
// kerl_dp
// Slot table, tag search, window check and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kerl_dp
  import kerl_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire kerl_cmd_t         cmd_i,
  output kerl_status_t           status_o,
  input  wire logic [KEY_W-1:0]  event_key_i,
  input  wire logic [TIME_W-1:0] now_time_i,
  input  wire logic [WIN_W-1:0]  window_i,
  output logic                   allowed_o,
  output logic [CNT_W-1:0]       repeat_count_o
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // latched item
  logic [KEY_W-1:0]  key_q;
  logic [TIME_W-1:0] now_q;

  // slot table
  logic [SLOT_COUNT-1:0] valid_q;
  logic [KEY_W-1:0]      tag_q     [SLOT_COUNT];
  logic [TIME_W-1:0]     stamp_mem [SLOT_COUNT];
  logic [CNT_W-1:0]      rep_mem   [SLOT_COUNT];
  logic [IDX_W-1:0]      victim_q;

  // lookup results
  logic             hit_c;
  logic [IDX_W-1:0] hit_idx_c;
  logic             hit_q;
  logic [IDX_W-1:0] hit_idx_q;
  logic [TIME_W-1:0] rd_stamp_q;
  logic [CNT_W-1:0]  rd_rep_q;

  // commit
  logic [TIME_W:0]   diff;
  logic              in_window;
  logic [CNT_W-1:0]  rep_inc;
  logic [CNT_W-1:0]  rep_wdata;
  logic [IDX_W-1:0]  wr_idx;
  logic              stamp_we;
  logic              allowed_d;
  logic [CNT_W-1:0]  count_d;
  logic              allowed_q;
  logic [CNT_W-1:0]  count_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      key_q <= event_key_i;
      now_q <= now_time_i;
    end
  end

  // lowest matching slot wins
  always_comb begin
    hit_c     = 1'b0;
    hit_idx_c = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (valid_q[i] && (tag_q[i] == key_q)) begin
        hit_c     = 1'b1;
        hit_idx_c = IDX_W'(i);
      end
    end
  end

  assign status_o.hit = hit_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q     <= 1'b0;
      hit_idx_q <= '0;
    end else if (cmd_i.match) begin
      hit_q     <= hit_c;
      hit_idx_q <= hit_idx_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      rd_stamp_q <= stamp_mem[hit_idx_q];
      rd_rep_q   <= rep_mem[hit_idx_q];
    end
  end

  // a borrow means time ran backwards: still inside the window
  assign diff      = {1'b0, now_q} - {1'b0, rd_stamp_q};
  assign in_window = diff[TIME_W] ||
                     (diff[TIME_W-1:0] < {{(TIME_W - WIN_W){1'b0}}, window_i});
  assign rep_inc   = (rd_rep_q == REPEAT_MAX) ? rd_rep_q : rd_rep_q + 1'b1;

  always_comb begin
    if (hit_q) begin
      wr_idx    = hit_idx_q;
      stamp_we  = !in_window;
      rep_wdata = in_window ? rep_inc : '0;
      allowed_d = !in_window;
      count_d   = in_window ? rep_inc : rd_rep_q;
    end else begin
      wr_idx    = victim_q;
      stamp_we  = 1'b1;
      rep_wdata = '0;
      allowed_d = 1'b1;
      count_d   = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rep_mem[wr_idx] <= rep_wdata;
      if (stamp_we) begin
        stamp_mem[wr_idx] <= now_q;
      end
      if (!hit_q) begin
        tag_q[victim_q] <= key_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      victim_q <= '0;
    end else if (cmd_i.commit && !hit_q) begin
      valid_q[victim_q] <= 1'b1;
      if (victim_q == IDX_W'(SLOT_COUNT - 1)) begin
        victim_q <= '0;
      end else begin
        victim_q <= victim_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      allowed_q <= allowed_d;
      count_q   <= count_d;
    end
  end

  assign allowed_o      = allowed_q;
  assign repeat_count_o = count_q;

endmodule

`default_nettype wire

// ===== design/keyed_event_rate_limiter_top.sv =====
// ----------------------------------------------------------------------------
// keyed_event_rate_limiter_top
// Per-key event rate limiter with a round-robin slot table.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i/in_ready_o) takes one item: event key and
//    current time. Output channel (out_valid_o/out_ready_i) returns one item
//    per input: allowed flag and repeat count.
//  - After acceptance an item goes through tag search, slot read (on a hit
//    only) and commit; the item is captured at the accepting edge. The
//    slot read is a registered read of the stamp/count store.
//  - The sequencer handles one item at a time and in_ready_o is high only
//    when it is idle, so a new item is taken only after the last commits.
//  - The result sits in an output register, so the next item is accepted and
//    looked up while the previous result waits. If the receiver stalls, the
//    sequencer holds in its commit step until the result register drains.
//  - Reset clears all slot valid bits and the victim pointer and loads the
//    window register with two hours (7200000000 us). No clearing pass.
//  - window_length is written over APB at address 0 (64-bit data, low 40
//    bits); the user must write it only while the block is idle, unchecked.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module keyed_event_rate_limiter_top
  import kerl_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // config port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  // input items
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [KEY_W-1:0]      event_key_i,
  input  wire logic [TIME_W-1:0]     now_time_i,
  // result items
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       allowed_o,
  output logic [CNT_W-1:0]           repeat_count_o
);

  logic [WIN_W-1:0] window_q;
  logic             cfg_wr;
  logic             sel_window;
  kerl_cmd_t        cmd;
  kerl_status_t     status;

  // --- config register ------------------------------------------------------
  assign pready     = 1'b1;
  assign sel_window = (paddr[CFG_IDX_LSB] == REG_WINDOW_IDX);
  assign cfg_wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
    end else if (cfg_wr && sel_window) begin
      window_q <= pwdata[WIN_W-1:0];
    end
  end

  assign prdata = sel_window ? {{(CFG_DATA_W - WIN_W){1'b0}}, window_q} : '0;

  // --- sequencer ------------------------------------------------------------
  kerl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // --- slot table and result path -------------------------------------------
  kerl_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .event_key_i    (event_key_i),
    .now_time_i     (now_time_i),
    .window_i       (window_q),
    .allowed_o      (allowed_o),
    .repeat_count_o (repeat_count_o)
  );

  // --- checks ---------------------------------------------------------------
  `ASSERT_NEVER(a_commit_no_overwrite, clk_i, rst_ni, cmd.commit && out_valid_o && !out_ready_i, "result overwritten while stalled")
  `ASSERT_PROP(a_one_item_in_flight, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o, "second item taken while busy")
  `ASSERT_NEVER(a_denied_nonzero, clk_i, rst_ni, out_valid_o && !allowed_o && (repeat_count_o == '0), "denied result with zero count")

endmodule

`default_nettype wire

// ===== tb/tb_keyed_event_rate_limiter_top.sv =====
// ----------------------------------------------------------------------------
// tb_keyed_event_rate_limiter_top
// Self-checking bench for the keyed event rate limiter.
// A short directed table covers key and time extremes, the window edge,
// time running backwards, slot eviction and writes to an unused register.
// Random phases follow, each with its own window: short and full-range
// windows, a window of zero, tight repeats, boundary steps and time jumps.
// Every result is checked against a behavioral copy of the slot table or a typed expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_keyed_event_rate_limiter_top;
  import kerl_pkg::*;

  localparam int SLOTS        = SLOT_COUNT_DEF;
  localparam int RESET_CYCLES = 11;
  // margin after the last result for the longest path, a hit
  localparam int DRAIN_CYCLES = 8;
  localparam int TAIL_CYCLES  = 20;
  // watchdog: a run that goes past this limit fails
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int MAX_PRINTS   = 30;
  localparam int PHASE_ITEMS  = 85;
  // long receiver hold-off: fires once after this many results
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 300;

  // register map
  localparam int WINDOW_REG = REG_WINDOW_IDX;
  localparam int SPARE_REG  = WINDOW_REG + 1;  // unmapped, writes ignored

  localparam logic [TIME_W-1:0] TIME_MAX   = '1;
  localparam logic [KEY_W-1:0]  KEY_ONES   = '1;
  localparam logic [WIN_W-1:0]  WINDOW_MAX = '1;
  localparam logic [TIME_W-1:0] TWO_HOURS  = TIME_W'(WINDOW_RESET);

  // one row of the directed table; expectation typed in only when known
  typedef struct {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
    bit                known;
    bit                allow;
    logic [CNT_W-1:0]  count;
  } event_row_t;

  typedef struct {
    bit               allow;
    logic [CNT_W-1:0] count;
  } verdict_t;

  // ---------------------------------------------------------------- DUT I/O
  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  psel           = 1'b0;
  logic                  penable        = 1'b0;
  logic                  pwrite         = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr          = '0;
  logic [CFG_DATA_W-1:0] pwdata         = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic [KEY_W-1:0]      event_key_i    = '0;
  logic [TIME_W-1:0]     now_time_i     = '0;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b0;
  logic                  allowed_o;
  logic [CNT_W-1:0]      repeat_count_o;

  keyed_event_rate_limiter_top #(.SLOT_COUNT(SLOTS)) dut (.*);

  // typed expectation travels with the item it belongs to
  bit               row_known = 1'b0;
  bit               row_allow = 1'b0;
  logic [CNT_W-1:0] row_count = '0;

  // ------------------------------------------------------- slot table model
  bit                tbl_valid   [SLOTS] = '{default: 1'b0};
  logic [KEY_W-1:0]  tbl_tag     [SLOTS];
  logic [TIME_W-1:0] tbl_stamp   [SLOTS];
  logic [CNT_W-1:0]  tbl_repeats [SLOTS];
  int unsigned       tbl_victim  = 0;
  logic [WIN_W-1:0]  tbl_window  = WINDOW_RESET;

  verdict_t   verdict_q [$];   // expected results, oldest first
  event_row_t dir_rows  [$];
  int         mismatches = 0;
  int         cycles     = 0;

  // sender controls
  int                burst_left = 0;
  logic [TIME_W-1:0] cur_time  = '0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Verdict for one event; updates the table as the block does.
  function automatic verdict_t limit_event(input logic [KEY_W-1:0] key,
                                           input logic [TIME_W-1:0] now);
    verdict_t    v;
    int          hit;
    logic [63:0] elapsed;
    hit = -1;
    // lowest matching slot wins
    for (int i = 0; i < SLOTS; i++) begin
      if (hit < 0 && tbl_valid[i] && tbl_tag[i] == key) hit = i;
    end
    if (hit >= 0) begin
      elapsed = 64'(now) - 64'(tbl_stamp[hit]);
      // time going backwards counts as inside the window
      if (now < tbl_stamp[hit] || elapsed < 64'(tbl_window)) begin
        if (tbl_repeats[hit] != REPEAT_MAX) tbl_repeats[hit] = tbl_repeats[hit] + 1'b1;
        v.allow = 1'b0;
        v.count = tbl_repeats[hit];
      end else begin
        v.allow = 1'b1;
        v.count = tbl_repeats[hit];
        tbl_repeats[hit] = '0;
        tbl_stamp[hit]   = now;
      end
    end else begin
      // miss: overwrite the round-robin victim
      tbl_valid[tbl_victim]   = 1'b1;
      tbl_tag[tbl_victim]     = key;
      tbl_stamp[tbl_victim]   = now;
      tbl_repeats[tbl_victim] = '0;
      tbl_victim = (tbl_victim + 1) % SLOTS;
      v.allow = 1'b1;
      v.count = '0;
    end
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, want, got);
  endtask

  function automatic void add_row(input logic [KEY_W-1:0] key, input logic [TIME_W-1:0] now,
                                  input bit known, input bit allow,
                                  input logic [CNT_W-1:0] count);
    dir_rows.push_back('{key, now, known, allow, count});
  endfunction

  // ---------------------------------------------------------------- monitor
  // Samples at the rising edge, so it sees the values from before the edge.
  always @(posedge clk_i) begin
    verdict_t want;
    verdict_t predicted;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else if (rst_ni) begin
      // register write lands at the access edge
      if (psel && penable && pwrite && pready &&
          paddr[CFG_ADDR_W-1:CFG_IDX_LSB] == REG_WINDOW_IDX)
        tbl_window = pwdata[WIN_W-1:0];

      if (out_valid_o && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result with nothing pending", '0, {allowed_o, repeat_count_o});
        end else begin
          want = verdict_q.pop_front();
          if (allowed_o !== want.allow)
            report_mismatch("allowed", want.allow, allowed_o);
          if (repeat_count_o !== want.count)
            report_mismatch("repeat_count", want.count, repeat_count_o);
        end
      end

      if (in_valid_i && in_ready_o) begin
        // the table model always runs; a typed row overrides its verdict
        predicted = limit_event(event_key_i, now_time_i);
        if (row_known) begin
          predicted.allow = row_allow;
          predicted.count = row_count;
        end
        verdict_q.push_back(predicted);
      end
    end
  end

  // --------------------------------------------------------------- receiver
  // Stalls in segments of random length and density; one long hold-off
  // lets the result register and the sequencer back up into the input.
  initial begin
    int seg_left;
    int seg_pct;
    int hold_left;
    int taken;
    bit hold_done;
    seg_left  = 0;
    seg_pct   = 0;
    hold_left = 0;
    taken     = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) taken++;
      if (!hold_done && taken >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(150, 10);
          case ($urandom_range(4))
            0, 1:    seg_pct = 0;
            2:       seg_pct = 25;
            3:       seg_pct = 60;
            default: seg_pct = 90;
          endcase
        end
        seg_left--;
        out_ready_i <= ($urandom_range(99) >= seg_pct);
      end
    end
  end

  // ----------------------------------------------------------------- sender
  // Offer one item and hold it until taken; bursts end in a gap of random length, at times none.
  task automatic push_event(input logic [KEY_W-1:0] key, input logic [TIME_W-1:0] now,
                            input bit known, input bit allow,
                            input logic [CNT_W-1:0] count);
    int gap;
    in_valid_i  <= 1'b1;
    event_key_i <= key;
    now_time_i  <= now;
    row_known   <= known;
    row_allow   <= allow;
    row_count   <= count;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Stop offering, let every result drain, then give the pipeline time.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup, then access; lands when pready is seen high.
  task automatic write_reg(input int idx, input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx << CFG_IDX_LSB);
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // APB read of the window register; only the 40 used bits are compared.
  task automatic check_window();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CFG_ADDR_W'(WINDOW_REG << CFG_IDX_LSB);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[WIN_W-1:0] !== tbl_window)
      report_mismatch("window readback", tbl_window, prdata[WIN_W-1:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // One random phase under a given window. Keys come mostly from a small
  // pool (sometimes under the slot count, sometimes well over it), so the
  // table sees both repeat hits and steady eviction.
  task automatic run_phase(input logic [WIN_W-1:0] window);
    logic [KEY_W-1:0]      pool [16];
    logic [KEY_W-1:0]      key;
    logic [CFG_DATA_W-1:0] cfg_word;
    logic [63:0]           span;
    logic [63:0]           delta;
    logic [63:0]           nxt;
    int                    pool_n;
    int                    r;
    wait_idle();
    cfg_word = rand64();  // upper bits are junk the block must drop
    cfg_word[WIN_W-1:0] = window;
    write_reg(WINDOW_REG, cfg_word);
    check_window();
    pool_n = $urandom_range(14, 3);
    for (int i = 0; i < pool_n; i++) pool[i] = rand64();
    if ($urandom_range(1)) cur_time = TIME_W'(rand64() >> 1);
    span = (window == '0) ? 64'd3 : 64'(window);
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      r = $urandom_range(99);
      if (r < 40)      delta = $urandom_range(3);
      else if (r < 70) delta = rand64() % (span / 2 + 1);
      else if (r < 85) delta = rand64() % (span * 2 + 1);
      else if (r < 92) delta = rand64() >> $urandom_range(63, 16);
      else             delta = rand64() % (span + 1);
      if (r >= 92) begin
        // step back in time
        cur_time = (delta > 64'(cur_time)) ? '0 : cur_time - TIME_W'(delta);
      end else begin
        nxt = 64'(cur_time) + delta;
        cur_time = (nxt > 64'(TIME_MAX)) ? TIME_W'(rand64() % (span * 4 + 1))
                                         : nxt[TIME_W-1:0];
      end
      key = ($urandom_range(99) < 80) ? pool[$urandom_range(pool_n - 1)] : rand64();
      push_event(key, cur_time, 1'b0, 1'b0, '0);
    end
  endtask

  // ------------------------------------------------------------------- main
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_window();  // reset value: two hours

    // Directed table, reset window. Slots fill 0..7 in order, then wrap.
    add_row('0,        '0,            1, 1, 0);  // new key
    add_row('0,        1,             1, 0, 1);  // repeat inside window
    add_row(KEY_ONES,  5,             1, 1, 0);  // second slot
    add_row('0,        TWO_HOURS - 1, 1, 0, 2);  // one short of the window
    add_row('0,        TWO_HOURS,     1, 1, 2);  // window just lapsed: restamp
    add_row('0,        TWO_HOURS,     1, 0, 1);
    add_row('0,        100,           1, 0, 2);  // time ran backwards
    add_row(KEY_ONES,  TIME_MAX,      1, 1, 0);  // largest time stamp
    add_row(KEY_ONES,  '0,            1, 0, 1);  // back to zero
    add_row(64'h8000_0000_0000_0000, 2 * TWO_HOURS, 1, 1, 0);
    add_row(64'h5555_5555_5555_5555, 2 * TWO_HOURS, 1, 1, 0);
    add_row(64'hAAAA_AAAA_AAAA_AAAA, 2 * TWO_HOURS, 1, 1, 0);
    add_row(64'd1,     2 * TWO_HOURS, 1, 1, 0);
    add_row(64'd2,     2 * TWO_HOURS, 1, 1, 0);
    add_row(64'd3,     2 * TWO_HOURS, 1, 1, 0);  // table full
    add_row(64'd4,     2 * TWO_HOURS, 1, 1, 0);  // evicts key zero
    add_row('0,        2 * TWO_HOURS, 1, 1, 0);  // evicted key is new again
    add_row(KEY_ONES,  2 * TWO_HOURS, 1, 1, 0);
    add_row(64'h5555_5555_5555_5555, 2 * TWO_HOURS + 1, 0, 0, 0);
    add_row('0,        3 * TWO_HOURS, 0, 0, 0);
    add_row(64'h8000_0000_0000_0000, 3 * TWO_HOURS, 0, 0, 0);
    add_row(64'h5555_5555_5555_5555, 3 * TWO_HOURS, 0, 0, 0);
    foreach (dir_rows[i])
      push_event(dir_rows[i].key, dir_rows[i].now, dir_rows[i].known,
                 dir_rows[i].allow, dir_rows[i].count);
    cur_time = 3 * TWO_HOURS;

    // write to the unmapped register must leave the window alone
    wait_idle();
    write_reg(SPARE_REG, rand64());
    check_window();

    // random phases: narrowest nonzero, widest, zero, short, any, reset value
    run_phase(40'd1);
    run_phase(WINDOW_MAX);
    run_phase('0);
    run_phase(WIN_W'($urandom_range(40, 2)));
    run_phase({8'($urandom_range(255)), 32'($urandom)});
    run_phase(WINDOW_RESET);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
